>>> src/tsk_pkg.sv
// Shared types and constants for the topological sort unit.
package tsk_pkg;

	localparam int NODE_SLOTS       = 32;
	localparam int NODE_W           = 5;
	localparam int COUNT_W          = 6;
	localparam int NODE_COUNT_RESET = 32;
	localparam int MAX_NODES_DEF    = 32;
	localparam int MAX_EDGES_DEF    = 128;

	// Command opcodes
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_SORT = 1'b1;

	typedef logic [NODE_W-1:0] node_t;

	// Operations on the indegree table
	typedef enum logic [1:0] {
		IOP_CLR,
		IOP_INC,
		IOP_DEC,
		IOP_READ
	} indeg_op_t;

	typedef struct packed {
		logic      valid;
		indeg_op_t op;
		node_t     addr;
	} indeg_req_t;

	typedef struct packed {
		logic      valid;
		indeg_op_t op;
		node_t     addr;
		logic      zero;
	} indeg_rsp_t;

	typedef struct packed {
		logic  load;
		logic  clear;
		node_t src;
		node_t dst;
	} edge_cmd_t;

endpackage

>>> src/topological_sort_kahn.sv
// Top level: command port, sort sequencer and ready queue.
//
//  Channel   Signals                                      Transaction when
//  command   start, busy, opcode, edge_source, edge_target start && !busy
//  result    strobe, has_node, node_index, is_last,       strobe (one cycle)
//            cycle_found, edges_dropped
//  config    cfg_valid, cfg_ready, cfg_data (node_count)  cfg_valid && cfg_ready
//
// An edge load is taken while busy stays low.
// A sort walks the edge memory's single read port once to count indegrees
// and once more for every sorted node, after a clearing pass over the
// indegree table.
// Reset clears control state and sets node_count to 32; no pass follows reset.
// Results leave one per strobe and cannot be held off by the receiver.
module topological_sort_kahn import tsk_pkg::*; #(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int MAX_EDGES = MAX_EDGES_DEF,
	localparam int AddrW = $clog2(MAX_EDGES),
	localparam int CntW  = $clog2(MAX_EDGES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               opcode,
	input  node_t              edge_source,
	input  node_t              edge_target,
	output logic               strobe,
	output logic               has_node,
	output node_t              node_index,
	output logic               is_last,
	output logic               cycle_found,
	output logic               edges_dropped,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COUNT_W-1:0] cfg_data
);

	localparam int NodeLimit = (MAX_NODES < NODE_SLOTS) ? MAX_NODES : NODE_SLOTS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_COUNT,
		ST_SCAN,
		ST_POP,
		ST_WAIT_Q,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] node_count_q;
	node_t              clr_idx_q;
	logic [CntW-1:0]    e_q;
	logic [COUNT_W-1:0] i_q;
	logic [COUNT_W-1:0] head_q;
	logic [COUNT_W-1:0] tail_q;
	node_t              cur_q;
	logic               pend_valid_q;
	node_t              pend_node_q;
	logic               run_drop_q;
	logic               edge_rd_s1;
	logic               strobe_q;
	logic               has_node_q;
	node_t              node_index_q;
	logic               is_last_q;
	logic               cycle_found_q;
	logic               edges_dropped_q;

	node_t              qmem [NODE_SLOTS];
	node_t              q_rd_q;

	logic [COUNT_W-1:0] n_eff;
	logic               accept;
	logic               edge_rd;
	logic               edge_ok;
	logic               edges_done;
	logic               push;
	edge_cmd_t          edge_cmd;
	node_t              rd_src;
	node_t              rd_dst;
	logic [CntW-1:0]    edge_total;
	logic               dropped;
	indeg_req_t         ireq;
	indeg_rsp_t         irsp;

	tsk_edge_store #(
		.MAX_EDGES(MAX_EDGES)
	) u_edges (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (edge_cmd),
		.node_limit(n_eff),
		.rd_addr   (e_q[AddrW-1:0]),
		.rd_src    (rd_src),
		.rd_dst    (rd_dst),
		.edge_total(edge_total),
		.dropped   (dropped)
	);

	tsk_indeg_unit #(
		.MAX_EDGES(MAX_EDGES)
	) u_indeg (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (ireq),
		.rsp   (irsp)
	);

	// Saturate the node count and decode the handshake
	always_comb begin
		n_eff  = (node_count_q > COUNT_W'(NodeLimit)) ? COUNT_W'(NodeLimit) : node_count_q;
		busy   = (state_q != ST_IDLE);
		accept = start && !busy;
		cfg_ready = !busy;
	end

	// Drive edge store commands and the edge walk
	always_comb begin
		edge_cmd.load  = accept && (opcode == OP_ADD);
		edge_cmd.clear = (state_q == ST_FINISH);
		edge_cmd.src   = edge_source;
		edge_cmd.dst   = edge_target;
		edge_rd        = ((state_q == ST_COUNT) || (state_q == ST_WALK)) && (e_q < edge_total);
		edge_ok        = ({1'b0, rd_src} < n_eff) && ({1'b0, rd_dst} < n_eff);
		edges_done     = !edge_rd && !edge_rd_s1 && !irsp.valid;
	end

	// Issue indegree operations for the current phase
	always_comb begin
		ireq.valid = 1'b0;
		ireq.op    = IOP_READ;
		ireq.addr  = i_q[NODE_W-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				ireq.valid = 1'b1;
				ireq.op    = IOP_CLR;
				ireq.addr  = clr_idx_q;
			end
			ST_COUNT: begin
				ireq.valid = edge_rd_s1 && edge_ok;
				ireq.op    = IOP_INC;
				ireq.addr  = rd_dst;
			end
			ST_SCAN: begin
				ireq.valid = (i_q < n_eff);
				ireq.op    = IOP_READ;
				ireq.addr  = i_q[NODE_W-1:0];
			end
			ST_WALK: begin
				ireq.valid = edge_rd_s1 && (rd_src == cur_q) && ({1'b0, rd_dst} < n_eff);
				ireq.op    = IOP_DEC;
				ireq.addr  = rd_dst;
			end
			default: begin
				ireq.valid = 1'b0;
			end
		endcase
		push = irsp.zero && ((irsp.op == IOP_READ) || (irsp.op == IOP_DEC)) &&
			(tail_q < COUNT_W'(NODE_SLOTS));
	end

	// Ready queue: append at tail, read at head every cycle
	always_ff @(posedge clk) begin
		if (push) begin
			qmem[tail_q[NODE_W-1:0]] <= irsp.addr;
		end
		q_rd_q <= qmem[head_q[NODE_W-1:0]];
	end

	// Sequence the sort and register results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			node_count_q    <= COUNT_W'(NODE_COUNT_RESET);
			clr_idx_q       <= '0;
			e_q             <= '0;
			i_q             <= '0;
			head_q          <= '0;
			tail_q          <= '0;
			cur_q           <= '0;
			pend_valid_q    <= 1'b0;
			pend_node_q     <= '0;
			run_drop_q      <= 1'b0;
			edge_rd_s1      <= 1'b0;
			strobe_q        <= 1'b0;
			has_node_q      <= 1'b0;
			node_index_q    <= '0;
			is_last_q       <= 1'b0;
			cycle_found_q   <= 1'b0;
			edges_dropped_q <= 1'b0;
		end else begin
			strobe_q   <= 1'b0;
			edge_rd_s1 <= edge_rd;
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
			// Empty the queue at the start of a sort, else advance the tail
			if (accept && (opcode == OP_SORT)) begin
				tail_q <= '0;
			end else if (push) begin
				tail_q <= tail_q + COUNT_W'(1);
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (opcode == OP_SORT)) begin
						state_q      <= ST_CLEAR;
						clr_idx_q    <= '0;
						run_drop_q   <= dropped;
						head_q       <= '0;
						pend_valid_q <= 1'b0;
					end
				end
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + NODE_W'(1);
					if (clr_idx_q == NODE_W'(NODE_SLOTS - 1)) begin
						state_q <= ST_COUNT;
						e_q     <= '0;
					end
				end
				ST_COUNT: begin
					if (edge_rd) begin
						e_q <= e_q + CntW'(1);
					end
					if (edge_rd_s1 && !edge_ok) begin
						run_drop_q <= 1'b1;
					end
					if (edges_done) begin
						state_q <= ST_SCAN;
						i_q     <= '0;
					end
				end
				ST_SCAN: begin
					if (i_q < n_eff) begin
						i_q <= i_q + COUNT_W'(1);
					end else if (!irsp.valid) begin
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					if (head_q < tail_q) begin
						head_q  <= head_q + COUNT_W'(1);
						state_q <= ST_WAIT_Q;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_WAIT_Q: begin
					// Emit the previous node now that another one follows
					if (pend_valid_q) begin
						strobe_q        <= 1'b1;
						has_node_q      <= 1'b1;
						node_index_q    <= pend_node_q;
						is_last_q       <= 1'b0;
						cycle_found_q   <= 1'b0;
						edges_dropped_q <= 1'b0;
					end
					pend_valid_q <= 1'b1;
					pend_node_q  <= q_rd_q;
					cur_q        <= q_rd_q;
					e_q          <= '0;
					state_q      <= ST_WALK;
				end
				ST_WALK: begin
					if (edge_rd) begin
						e_q <= e_q + CntW'(1);
					end
					if (edges_done) begin
						state_q <= ST_POP;
					end
				end
				ST_FINISH: begin
					// Emit the final node, or an empty result when none sorted
					strobe_q        <= 1'b1;
					has_node_q      <= pend_valid_q;
					node_index_q    <= pend_valid_q ? pend_node_q : '0;
					is_last_q       <= 1'b1;
					cycle_found_q   <= (head_q < n_eff);
					edges_dropped_q <= run_drop_q;
					state_q         <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe        = strobe_q;
	assign has_node      = has_node_q;
	assign node_index    = node_index_q;
	assign is_last       = is_last_q;
	assign cycle_found   = cycle_found_q;
	assign edges_dropped = edges_dropped_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && !has_node_q) |-> is_last_q)
		else $error("empty result that is not the last");

	assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("ready queue read past its tail");

	assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && is_last_q) |-> !busy)
		else $error("last result while the sort still runs");

	assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> ($past(state_q) == ST_WAIT_Q) || ($past(state_q) == ST_FINISH))
		else $error("result strobe outside emission");

endmodule

>>> src/tsk_edge_store.sv
// Edge list memory with edge counter and dropped-edge flag.
module tsk_edge_store import tsk_pkg::*; #(
	parameter int MAX_EDGES = MAX_EDGES_DEF,
	localparam int AddrW = $clog2(MAX_EDGES),
	localparam int CntW  = $clog2(MAX_EDGES + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  edge_cmd_t          cmd,
	input  logic [COUNT_W-1:0] node_limit,
	input  logic [AddrW-1:0]   rd_addr,
	output node_t              rd_src,
	output node_t              rd_dst,
	output logic [CntW-1:0]    edge_total,
	output logic               dropped
);

	logic [2*NODE_W-1:0] mem [MAX_EDGES];
	logic [2*NODE_W-1:0] rd_q;
	logic [CntW-1:0]     total_q;
	logic                drop_q;
	logic                store_ok;

	// Accept an edge only when both ends exist and there is room
	always_comb begin
		store_ok = ({1'b0, cmd.src} < node_limit) && ({1'b0, cmd.dst} < node_limit) &&
			(total_q != CntW'(MAX_EDGES));
	end

	// Write new edges at the fill count, read one entry a cycle
	always_ff @(posedge clk) begin
		if (cmd.load && store_ok) begin
			mem[total_q[AddrW-1:0]] <= {cmd.src, cmd.dst};
		end
		rd_q <= mem[rd_addr];
	end

	// Track fill count and drops; clear both after a sort
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.clear) begin
			total_q <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.load) begin
			if (store_ok) begin
				total_q <= total_q + CntW'(1);
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

	assign rd_src     = rd_q[2*NODE_W-1:NODE_W];
	assign rd_dst     = rd_q[NODE_W-1:0];
	assign edge_total = total_q;
	assign dropped    = drop_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CntW'(MAX_EDGES))
		else $error("edge count beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && !cmd.clear && !store_ok) |=> drop_q)
		else $error("rejected edge did not raise the drop flag");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (total_q == '0) && !drop_q)
		else $error("edge list not cleared");

endmodule

>>> src/tsk_indeg_unit.sv
// Indegree table memory with read-modify-write stage and write forwarding.
module tsk_indeg_unit import tsk_pkg::*; #(
	parameter int MAX_EDGES = MAX_EDGES_DEF,
	localparam int CntW = $clog2(MAX_EDGES + 1)
) (
	input  logic       clk,
	input  logic       arst_n,
	input  indeg_req_t req,
	output indeg_rsp_t rsp
);

	logic [CntW-1:0] mem [NODE_SLOTS];
	logic [CntW-1:0] rd_s1;
	indeg_req_t      req_s1;
	logic            fwd_valid_q;
	node_t           fwd_addr_q;
	logic [CntW-1:0] fwd_data_q;
	logic [CntW-1:0] old_val;
	logic            wr_en_s1;
	logic [CntW-1:0] wr_data_s1;
	logic            zero_s1;

	// Modify stage: take the last write when it hit the same entry
	always_comb begin
		old_val    = (fwd_valid_q && (fwd_addr_q == req_s1.addr)) ? fwd_data_q : rd_s1;
		wr_en_s1   = 1'b0;
		wr_data_s1 = old_val;
		zero_s1    = 1'b0;
		case (req_s1.op)
			IOP_INC: begin
				wr_en_s1   = req_s1.valid;
				wr_data_s1 = old_val + CntW'(1);
			end
			IOP_DEC: begin
				wr_en_s1   = req_s1.valid && (old_val != '0);
				wr_data_s1 = old_val - CntW'(1);
				zero_s1    = (old_val == CntW'(1));
			end
			IOP_READ: begin
				zero_s1 = (old_val == '0);
			end
			default: begin
				zero_s1 = 1'b0;
			end
		endcase
	end

	// Write back modified entries or clear; read one entry a cycle
	always_ff @(posedge clk) begin
		if (wr_en_s1) begin
			mem[req_s1.addr] <= wr_data_s1;
		end else if (req.valid && (req.op == IOP_CLR)) begin
			mem[req.addr] <= '0;
		end
		rd_s1      <= mem[req.addr];
		fwd_addr_q <= req_s1.addr;
		fwd_data_q <= wr_data_s1;
	end

	// Advance the request and the forwarding flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1      <= '0;
			fwd_valid_q <= 1'b0;
		end else begin
			req_s1      <= req;
			fwd_valid_q <= wr_en_s1;
		end
	end

	assign rsp.valid = req_s1.valid;
	assign rsp.op    = req_s1.op;
	assign rsp.addr  = req_s1.addr;
	assign rsp.zero  = req_s1.valid && zero_s1;

	assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && (req.op == IOP_CLR)) |-> !wr_en_s1)
		else $error("clear collides with a pending write");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.zero |-> ((rsp.op == IOP_READ) || (rsp.op == IOP_DEC)))
		else $error("zero flag on an operation that does not report it");

	assert property (@(posedge clk) disable iff (!arst_n)
		(req_s1.valid && (req_s1.op == IOP_INC)) |=> fwd_valid_q)
		else $error("increment did not write back");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the topological sort unit: directed table, then random graphs.
module testbench;
	import tsk_pkg::*;

	localparam int   MAX_REPORTS   = 10;
	localparam int   SETTLE_CYCLES = 16;
	localparam int   RANDOM_ITEMS  = 250;
	localparam int   BIG_AT        = 40;
	localparam int   QUIET_FROM    = 180;
	localparam int   QUIET_TO      = 240;

	typedef enum logic [1:0] {
		ROW_CFG,
		ROW_EDGE,
		ROW_SORT
	} row_kind_t;

	typedef struct packed {
		logic  has_node;
		node_t node_index;
		logic  is_last;
		logic  cycle_found;
		logic  edges_dropped;
	} order_t;

	typedef struct {
		row_kind_t kind;
		int        a;
		int        b;
		bit        typed;
		order_t    want;
	} script_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               opcode;
	node_t              edge_source;
	node_t              edge_target;
	logic               strobe;
	logic               has_node;
	node_t              node_index;
	logic               is_last;
	logic               cycle_found;
	logic               edges_dropped;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [COUNT_W-1:0] cfg_data;

	// Shadow state of the graph held by the block
	logic [COUNT_W-1:0] node_count_m;
	node_t              edge_src_m [MAX_EDGES_DEF];
	node_t              edge_dst_m [MAX_EDGES_DEF];
	int                 edge_total_m;
	bit                 dropped_m;
	order_t             sorted [NODE_SLOTS];
	int                 sorted_len;

	order_t      order_due [$];
	script_row_t script [$];
	int          mismatches;
	int          stray;
	int          items_sent;
	int          edges_sent;
	int          sorts_sent;
	int          results_seen;

	topological_sort_kahn dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.edge_source  (edge_source),
		.edge_target  (edge_target),
		.strobe       (strobe),
		.has_node     (has_node),
		.node_index   (node_index),
		.is_last      (is_last),
		.cycle_found  (cycle_found),
		.edges_dropped(edges_dropped),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Saturate the register to the node slots that exist
	function automatic int live_nodes();
		int n;
		n = node_count_m;
		if (n > MAX_NODES_DEF) n = MAX_NODES_DEF;
		if (n > NODE_SLOTS) n = NODE_SLOTS;
		return n;
	endfunction

	function automatic void load_edge(node_t s, node_t d);
		int n;
		n = live_nodes();
		if (s >= n || d >= n || edge_total_m >= MAX_EDGES_DEF) begin
			dropped_m = 1'b1;
		end else begin
			edge_src_m[edge_total_m] = s;
			edge_dst_m[edge_total_m] = d;
			edge_total_m++;
		end
	endfunction

	// Append one expected result to the tail of the queue
	function automatic void expect_result(order_t o);
		order_due = {order_due, o};
	endfunction

	// Append one row to the directed table
	function automatic void add_row(script_row_t r);
		script = {script, r};
	endfunction

	// Kahn's algorithm over the stored edges; fills sorted[] and clears the edge list
	function automatic void kahn_order();
		int    n;
		int    indeg [NODE_SLOTS];
		node_t ready [NODE_SLOTS];
		int    head;
		int    tail;
		node_t cur;
		bit    drop;
		n = live_nodes();
		drop = dropped_m;
		head = 0;
		tail = 0;
		sorted_len = 0;
		for (int i = 0; i < NODE_SLOTS; i++) indeg[i] = 0;
		for (int e = 0; e < edge_total_m; e++) begin
			if (edge_src_m[e] >= n || edge_dst_m[e] >= n) drop = 1'b1;
			else indeg[edge_dst_m[e]]++;
		end
		for (int i = 0; i < n; i++) begin
			if (indeg[i] == 0) begin
				ready[tail] = node_t'(i);
				tail++;
			end
		end
		while (head < tail) begin
			cur = ready[head];
			head++;
			sorted[sorted_len] = '{1'b1, cur, 1'b0, 1'b0, 1'b0};
			sorted_len++;
			// Release successors in load order
			for (int e = 0; e < edge_total_m; e++) begin
				if (edge_src_m[e] == cur && edge_dst_m[e] < n && indeg[edge_dst_m[e]] > 0) begin
					indeg[edge_dst_m[e]]--;
					if (indeg[edge_dst_m[e]] == 0) begin
						ready[tail] = edge_dst_m[e];
						tail++;
					end
				end
			end
		end
		if (sorted_len == 0) begin
			sorted[0] = '{1'b0, node_t'(0), 1'b1, (n > 0), drop};
			sorted_len = 1;
		end else begin
			sorted[sorted_len-1].is_last = 1'b1;
			sorted[sorted_len-1].cycle_found = (sorted_len < n);
			sorted[sorted_len-1].edges_dropped = drop;
		end
		edge_total_m = 0;
		dropped_m = 1'b0;
	endfunction

	function automatic script_row_t mk(row_kind_t kind, int a, int b, bit typed = 1'b0,
			order_t want = '0);
		script_row_t r;
		r.kind = kind;
		r.a = a;
		r.b = b;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic int pick_count();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 1;
			2: return 32;
			3: return 63;
			4: return $urandom_range(0, 63);
			default: return $urandom_range(2, 12);
		endcase
	endfunction

	// Hold start low for a random number of cycles, except in the quiet stretch
	task automatic idle_gap();
		if (items_sent >= QUIET_FROM && items_sent < QUIET_TO) return;
		while ($urandom_range(0, 99) < 20) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Drive one command transaction and predict what it returns
	task automatic issue(logic op, node_t s, node_t d, bit typed, order_t want);
		idle_gap();
		start <= 1'b1;
		opcode <= op;
		edge_source <= s;
		edge_target <= d;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
		if (op == OP_ADD) begin
			load_edge(s, d);
			edges_sent++;
		end else begin
			kahn_order();
			sorts_sent++;
			if (typed) expect_result(want);
			else for (int k = 0; k < sorted_len; k++) expect_result(sorted[k]);
		end
	endtask

	// Write node_count once the block has drained
	task automatic write_count(int v);
		start <= 1'b0;
		while (order_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= COUNT_W'(v);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		node_count_m = COUNT_W'(v);
	endtask

	task automatic random_edge();
		int    n;
		int    r;
		node_t s;
		node_t d;
		n = live_nodes();
		r = $urandom_range(0, 99);
		if (n >= 2 && r < 65) begin
			// Forward edge keeps the graph acyclic
			s = node_t'($urandom_range(0, n - 2));
			d = node_t'($urandom_range(s + 1, n - 1));
		end else if (n >= 1 && r < 85) begin
			s = node_t'($urandom_range(0, n - 1));
			d = node_t'($urandom_range(0, n - 1));
		end else begin
			s = node_t'($urandom);
			d = node_t'($urandom);
		end
		issue(OP_ADD, s, d, 1'b0, '0);
	endtask

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		order_t got;
		order_t want;
		if (arst_n && strobe) begin
			got = '{has_node, node_index, is_last, cycle_found, edges_dropped};
			results_seen++;
			if (order_due.size() == 0) begin
				stray++;
				if (mismatches + stray <= MAX_REPORTS)
					$display("unexpected result: has=%0d node=%0d last=%0d cyc=%0d drop=%0d",
						got.has_node, got.node_index, got.is_last, got.cycle_found,
						got.edges_dropped);
			end else begin
				want = order_due.pop_front();
				if (got.has_node !== want.has_node || got.node_index !== want.node_index ||
						got.is_last !== want.is_last || got.cycle_found !== want.cycle_found ||
						got.edges_dropped !== want.edges_dropped) begin
					mismatches++;
					if (mismatches + stray <= MAX_REPORTS)
						$display("mismatch: expected has=%0d node=%0d last=%0d cyc=%0d drop=%0d, %s",
							want.has_node, want.node_index, want.is_last, want.cycle_found,
							want.edges_dropped,
							$sformatf("got has=%0d node=%0d last=%0d cyc=%0d drop=%0d",
								got.has_node, got.node_index, got.is_last, got.cycle_found,
								got.edges_dropped));
				end
			end
		end
	end

	initial begin
		int  phase_edges;
		bit  big_done;
		int  goal;
		arst_n <= 1'b0;
		start <= 1'b0;
		opcode <= OP_ADD;
		edge_source <= '0;
		edge_target <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		node_count_m = COUNT_W'(NODE_COUNT_RESET);
		edge_total_m = 0;
		dropped_m = 1'b0;
		mismatches = 0;
		stray = 0;
		items_sent = 0;
		edges_sent = 0;
		sorts_sent = 0;
		results_seen = 0;
		big_done = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Empty graph at reset count: every node in index order
		add_row(mk(ROW_SORT, 0, 0));
		// Zero nodes: one empty result, no cycle
		add_row(mk(ROW_CFG, 0, 0));
		add_row(mk(ROW_SORT, 0, 0, 1'b1, '{1'b0, 5'd0, 1'b1, 1'b0, 1'b0}));
		// Edge naming an absent node is dropped and reported
		add_row(mk(ROW_EDGE, 0, 0));
		add_row(mk(ROW_CFG, 1, 0));
		add_row(mk(ROW_SORT, 0, 0, 1'b1, '{1'b1, 5'd0, 1'b1, 1'b0, 1'b1}));
		// Self loop on the only node: nothing sorted, cycle flagged
		add_row(mk(ROW_EDGE, 0, 0));
		add_row(mk(ROW_SORT, 0, 0, 1'b1, '{1'b0, 5'd0, 1'b1, 1'b1, 1'b0}));
		// Two-node cycle across the extreme indexes
		add_row(mk(ROW_CFG, 32, 0));
		add_row(mk(ROW_EDGE, 31, 0));
		add_row(mk(ROW_EDGE, 0, 31));
		add_row(mk(ROW_EDGE, 5, 31));
		add_row(mk(ROW_SORT, 0, 0));
		// Over-range count saturates; duplicate edge counts twice; count lowered before sort
		add_row(mk(ROW_CFG, 63, 0));
		add_row(mk(ROW_EDGE, 5, 3));
		add_row(mk(ROW_EDGE, 5, 3));
		add_row(mk(ROW_EDGE, 3, 1));
		add_row(mk(ROW_EDGE, 2, 5));
		add_row(mk(ROW_EDGE, 2, 3));
		add_row(mk(ROW_CFG, 4, 0));
		add_row(mk(ROW_SORT, 0, 0));
		// Reverse order against index order
		add_row(mk(ROW_CFG, 2, 0));
		add_row(mk(ROW_EDGE, 1, 0));
		add_row(mk(ROW_SORT, 0, 0));

		foreach (script[r]) begin
			case (script[r].kind)
				ROW_CFG:  write_count(script[r].a);
				ROW_EDGE: issue(OP_ADD, node_t'(script[r].a), node_t'(script[r].b), 1'b0, '0);
				default:  issue(OP_SORT, node_t'($urandom), node_t'($urandom), script[r].typed,
					script[r].want);
			endcase
		end

		// Random graphs: one phase of edges, then a sort
		goal = items_sent + RANDOM_ITEMS;
		while (items_sent < goal) begin
			if (!big_done && items_sent >= BIG_AT) begin
				// Overfill the edge store once
				write_count(32);
				phase_edges = MAX_EDGES_DEF + 2;
				big_done = 1'b1;
			end else begin
				if ($urandom_range(0, 99) < 60) write_count(pick_count());
				phase_edges = $urandom_range(0, 10);
			end
			for (int k = 0; k < phase_edges; k++) random_edge();
			if ($urandom_range(0, 99) < 15) write_count($urandom_range(0, node_count_m));
			issue(OP_SORT, node_t'($urandom), node_t'($urandom), 1'b0, '0);
		end

		// Drain outstanding results
		start <= 1'b0;
		while (order_due.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		$display("Ran %0d command transactions: %0d edge loads and %0d sorts.",
			items_sent, edges_sent, sorts_sent);
		$display("Checked %0d result transactions; %0d wrong, %0d unexpected.",
			results_seen, mismatches, stray);
		if (mismatches == 0 && stray == 0 && order_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Drop the run if it hangs
	initial begin
		#1000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
